[src/battery_threshold_monitor_assert.svh]
// Assertion macros shared by the battery threshold monitor modules.
`ifndef BATTERY_THRESHOLD_MONITOR_ASSERT_SVH
`define BATTERY_THRESHOLD_MONITOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BTM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("battery_threshold_monitor: assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BTM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("battery_threshold_monitor: assertion failed");

`endif

[src/bthm_pkg.sv]
// Shared widths, constants and types of the battery threshold monitor.
package bthm_pkg;

	localparam int PCT_W      = 7;
	localparam int KIND_W     = 2;
	localparam int DATA_W     = 32;
	localparam int WAIT_W     = 9;
	localparam int STEP_W     = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [WAIT_W-1:0] WAIT_MIN   = 9'd20;
	localparam logic [WAIT_W-1:0] WAIT_MAX   = 9'd300;
	localparam logic [WAIT_W-1:0] WAIT_MAINS = 9'd300;
	localparam logic [WAIT_W-1:0] WAIT_BLIND = 9'd120;

	localparam logic [PCT_W-1:0] REARM_MARGIN = 7'd3;

	localparam logic [PCT_W-1:0]  RST_WARN_LEVEL    = 7'd20;
	localparam logic [PCT_W-1:0]  RST_URGENT_LEVEL  = 7'd10;
	localparam logic [PCT_W-1:0]  RST_SHELTER_LEVEL = 7'd5;
	localparam logic [KIND_W-1:0] RST_SHELTER_KIND  = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_WARN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_URGENT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHELTER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KIND    = 3'd3;

	typedef struct packed {
		logic [PCT_W-1:0]  warn_level;
		logic [PCT_W-1:0]  urgent_level;
		logic [PCT_W-1:0]  shelter_level;
		logic [KIND_W-1:0] shelter_kind;
	} cfg_regs_t;

	typedef struct packed {
		logic              plugged;
		logic              unplugged;
		logic [STEP_W-1:0] step;
		logic              warn;
		logic              urgent;
		logic              shelter;
		logic [KIND_W-1:0] request;
	} alarm_res_t;

	typedef struct packed {
		logic start;
		logic take;
	} wait_cmd_t;

	typedef struct packed {
		logic idle;
		logic done;
	} wait_sts_t;

endpackage

[src/bthm_alarm.sv]
// Threshold hysteresis, mains edge detection and shelter latch of the monitor.
`include "battery_threshold_monitor_assert.svh"

module bthm_alarm (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [bthm_pkg::PCT_W-1:0]     level_percent,
	input  logic                           mains_present,
	input  logic                           reading_ok,
	input  bthm_pkg::cfg_regs_t            cfg,
	output bthm_pkg::alarm_res_t           res
);
	import bthm_pkg::*;

	logic [2:0]                armed_q;
	logic                      mains_before_q;
	logic                      mains_known_q;
	logic                      shelter_done_q;
	logic [2:0]                armed_d;
	logic                      shelter_done_d;
	logic [2:0]                fired;
	logic [2:0][PCT_W-1:0]     lv;

	// Percent rounded to the nearest ten; divide by ten via reciprocal 205/2048.
	function automatic logic [STEP_W-1:0] round_step(input logic [PCT_W-1:0] p);
		logic [7:0]  s;
		logic [15:0] m;
		logic [3:0]  q;
		logic [7:0]  r;
		s = {1'b0, p} + 8'd5;
		m = 16'(s) * 16'd205;
		q = m[14:11];
		r = 8'(q) * 8'd10;
		if (r > 8'd100) begin
			r = 8'd100;
		end
		return r[STEP_W-1:0];
	endfunction

	assign lv = {cfg.shelter_level, cfg.urgent_level, cfg.warn_level};

	always_comb begin
		res            = '0;
		armed_d        = armed_q;
		shelter_done_d = shelter_done_q;
		fired          = '0;
		if (reading_ok) begin
			if (mains_known_q && mains_present && !mains_before_q) begin
				res.plugged    = 1'b1;
				armed_d        = 3'b111;
				shelter_done_d = 1'b0;
			end else if (mains_known_q && !mains_present && mains_before_q) begin
				res.unplugged = 1'b1;
				res.step      = round_step(level_percent);
			end
			if (!mains_present) begin
				for (int i = 0; i < 3; i++) begin
					if (!armed_d[i] &&
					    ({1'b0, level_percent} > ({1'b0, lv[i]} + {1'b0, REARM_MARGIN}))) begin
						armed_d[i] = 1'b1;
					end
					if (armed_d[i] && (level_percent <= lv[i])) begin
						armed_d[i] = 1'b0;
						fired[i]   = 1'b1;
					end
				end
			end
			res.warn   = fired[0];
			res.urgent = fired[1];
			// The shelter action is requested once per discharge only.
			if (fired[2] && !shelter_done_d) begin
				shelter_done_d = 1'b1;
				res.shelter    = 1'b1;
				res.request    = cfg.shelter_kind;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q        <= 3'b111;
			mains_before_q <= 1'b0;
			mains_known_q  <= 1'b0;
			shelter_done_q <= 1'b0;
		end else if (accept && reading_ok) begin
			armed_q        <= armed_d;
			mains_before_q <= mains_present;
			mains_known_q  <= 1'b1;
			shelter_done_q <= shelter_done_d;
		end
	end

	`BTM_ASSERT_NXT(a_shelter_latched, accept && res.shelter, shelter_done_q)
	`BTM_ASSERT_IMP(a_plug_no_fire, accept && res.plugged, !(res.warn || res.urgent || res.shelter))
	`BTM_ASSERT_IMP(a_fail_no_event, accept && !reading_ok, res == '0)

endmodule

[src/bthm_wait.sv]
// Serial unit for the next read interval: shift-add multiply, then restoring divide.
`include "battery_threshold_monitor_assert.svh"

module bthm_wait (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bthm_pkg::wait_cmd_t             cmd,
	output bthm_pkg::wait_sts_t             sts,
	input  logic [bthm_pkg::PCT_W-1:0]      level_percent,
	input  logic                            mains_present,
	input  logic                            reading_ok,
	input  logic                            charge_ok,
	input  logic [bthm_pkg::DATA_W-1:0]     charge_left,
	input  logic [bthm_pkg::DATA_W-1:0]     charge_cap,
	input  logic [bthm_pkg::DATA_W-1:0]     drain_now,
	input  bthm_pkg::cfg_regs_t             cfg,
	output logic [bthm_pkg::WAIT_W-1:0]     wait_s
);
	import bthm_pkg::*;

	// The dividend is 9*(100*now - target*full) = 900*now - (9*target)*full.
	localparam int MUL_STEPS = 11;
	localparam int ACC_W     = 43;
	localparam int CNT_W     = 4;
	localparam logic [MUL_STEPS-1:0] K_NOW = 11'd900;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_SAT   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_CLAMP = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MUL_STEPS-1:0] kc_q;
	logic [MUL_STEPS-1:0] kt_q;
	logic [DATA_W-1:0]    now_q;
	logic [DATA_W-1:0]    full_q;
	logic [ACC_W-1:0]     pos_q;
	logic [ACC_W-1:0]     neg_q;
	logic [ACC_W-1:0]     dv_q;
	logic [WAIT_W-1:0]    q_q;
	logic [PCT_W-1:0]     target;
	logic                 blind;
	logic                 rem_ge;

	// Highest threshold strictly below the percent, zero when there is none.
	always_comb begin
		target = '0;
		if ((cfg.warn_level < level_percent) && (cfg.warn_level > target)) begin
			target = cfg.warn_level;
		end
		if ((cfg.urgent_level < level_percent) && (cfg.urgent_level > target)) begin
			target = cfg.urgent_level;
		end
		if ((cfg.shelter_level < level_percent) && (cfg.shelter_level > target)) begin
			target = cfg.shelter_level;
		end
	end

	assign blind  = !charge_ok || (charge_cap == '0) || (drain_now == '0);
	assign rem_ge = (pos_q >= dv_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						if (!reading_ok || mains_present || blind) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
							cnt_q   <= CNT_W'(MUL_STEPS - 1);
						end
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= ST_CMP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_CMP: begin
					state_q <= (pos_q <= neg_q) ? ST_DONE : ST_SAT;
				end
				ST_SAT: begin
					if (rem_ge) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
						cnt_q   <= CNT_W'(WAIT_W - 1);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_CLAMP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_CLAMP: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cmd.take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!reading_ok) begin
					q_q <= WAIT_BLIND;
				end else if (mains_present) begin
					q_q <= WAIT_MAINS;
				end else if (blind) begin
					q_q <= WAIT_BLIND;
				end
				now_q  <= charge_left;
				full_q <= charge_cap;
				kc_q   <= K_NOW;
				kt_q   <= MUL_STEPS'({target, 3'b000}) + MUL_STEPS'(target);
				pos_q  <= '0;
				neg_q  <= '0;
				dv_q   <= {2'b00, drain_now, 9'd0};
			end
			ST_MUL: begin
				// One constant bit per cycle, most significant first.
				pos_q <= {pos_q[ACC_W-2:0], 1'b0} + (kc_q[MUL_STEPS-1] ? ACC_W'(now_q) : '0);
				neg_q <= {neg_q[ACC_W-2:0], 1'b0} + (kt_q[MUL_STEPS-1] ? ACC_W'(full_q) : '0);
				kc_q  <= {kc_q[MUL_STEPS-2:0], 1'b0};
				kt_q  <= {kt_q[MUL_STEPS-2:0], 1'b0};
			end
			ST_CMP: begin
				if (pos_q <= neg_q) begin
					q_q <= WAIT_MIN;
				end else begin
					pos_q <= pos_q - neg_q;
				end
			end
			ST_SAT: begin
				// A quotient of 512 or more is clamped without dividing.
				if (rem_ge) begin
					q_q <= WAIT_MAX;
				end else begin
					q_q <= '0;
				end
				dv_q <= {1'b0, dv_q[ACC_W-1:1]};
			end
			ST_DIV: begin
				if (rem_ge) begin
					pos_q <= pos_q - dv_q;
				end
				q_q  <= {q_q[WAIT_W-2:0], rem_ge};
				dv_q <= {1'b0, dv_q[ACC_W-1:1]};
			end
			ST_CLAMP: begin
				if (q_q < WAIT_MIN) begin
					q_q <= WAIT_MIN;
				end else if (q_q > WAIT_MAX) begin
					q_q <= WAIT_MAX;
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.idle = (state_q == ST_IDLE);
	assign sts.done = (state_q == ST_DONE);
	assign wait_s   = q_q;

	`BTM_ASSERT_IMP(a_start_when_idle, cmd.start, state_q == ST_IDLE)
	`BTM_ASSERT_IMP(a_wait_in_range, sts.done, (wait_s >= WAIT_MIN) && (wait_s <= WAIT_MAX))
	`BTM_ASSERT_IMP(a_div_bound, state_q == ST_DIV, pos_q < (dv_q << 1))

endmodule

[src/battery_threshold_monitor.sv]
// Top level of the battery threshold monitor: config registers, control and output register.
//
// One input item is one battery reading; each accepted item yields exactly one result item.
// Input and output channels use valid/ready; an item moves on an edge where both are high.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user must write it
// only while idle, and the block itself does not enforce this. Indexes 0..3 select warn,
// urgent and shelter levels and the shelter kind, others are ignored. Threshold, hysteresis
// and mains edge logic is evaluated in the accept cycle. The read interval is then worked
// out by a serial unit: an 11-step shift-add multiply (one constant bit per cycle), a
// compare, a range check and a 9-step restoring divide (one quotient bit per cycle),
// followed by a clamp to 20..300 s. For a failed reading, mains power or missing charge
// data the unit skips these steps and goes straight to its done state. The serial interval
// unit holds one item at a time, so the next item is taken in the cycle after the result
// leaves the unit. The result sits in an output register; a new item is accepted while it
// waits, but the unit holds its finished value until the receiver takes the pending one.
// Reset (arst_n low) arms all three thresholds, forgets the mains state, clears the shelter
// latch, loads the default levels (20, 10, 5, hibernate) and empties the output register.
`include "battery_threshold_monitor_assert.svh"

module battery_threshold_monitor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bthm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bthm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bthm_pkg::PCT_W-1:0]         level_percent,
	input  logic                               mains_present,
	input  logic                               reading_ok,
	input  logic                               charge_ok,
	input  logic [bthm_pkg::DATA_W-1:0]        charge_left,
	input  logic [bthm_pkg::DATA_W-1:0]        charge_cap,
	input  logic [bthm_pkg::DATA_W-1:0]        drain_now,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               plugged_event,
	output logic                               unplugged_event,
	output logic [bthm_pkg::STEP_W-1:0]        unplug_step,
	output logic                               warn_fired,
	output logic                               urgent_fired,
	output logic                               shelter_fired,
	output logic [bthm_pkg::KIND_W-1:0]        shelter_request,
	output logic [bthm_pkg::WAIT_W-1:0]        next_wait_s
);
	import bthm_pkg::*;

	cfg_regs_t         cfg_q;
	alarm_res_t        alarm_res;
	alarm_res_t        flags_s1;
	alarm_res_t        res_q;
	logic [WAIT_W-1:0] wait_s;
	logic [WAIT_W-1:0] wait_q;
	logic              out_valid_q;
	logic              accept;
	wait_cmd_t         wait_cmd;
	wait_sts_t         wait_sts;

	// Configuration registers; an unknown index leaves all of them unchanged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warn_level    <= RST_WARN_LEVEL;
			cfg_q.urgent_level  <= RST_URGENT_LEVEL;
			cfg_q.shelter_level <= RST_SHELTER_LEVEL;
			cfg_q.shelter_kind  <= RST_SHELTER_KIND;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WARN:    cfg_q.warn_level    <= cfg_data[PCT_W-1:0];
				CFG_URGENT:  cfg_q.urgent_level  <= cfg_data[PCT_W-1:0];
				CFG_SHELTER: cfg_q.shelter_level <= cfg_data[PCT_W-1:0];
				CFG_KIND:    cfg_q.shelter_kind  <= cfg_data[KIND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The interval unit is free exactly when a new reading may enter.
	assign in_ready = wait_sts.idle;
	assign accept   = in_valid && in_ready;

	// A finished interval leaves the unit once the output register is empty or being emptied.
	assign wait_cmd.start = accept;
	assign wait_cmd.take  = wait_sts.done && (!out_valid_q || out_ready);

	bthm_alarm u_alarm (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.level_percent (level_percent),
		.mains_present (mains_present),
		.reading_ok    (reading_ok),
		.cfg           (cfg_q),
		.res           (alarm_res)
	);

	bthm_wait u_wait (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (wait_cmd),
		.sts           (wait_sts),
		.level_percent (level_percent),
		.mains_present (mains_present),
		.reading_ok    (reading_ok),
		.charge_ok     (charge_ok),
		.charge_left   (charge_left),
		.charge_cap    (charge_cap),
		.drain_now     (drain_now),
		.cfg           (cfg_q),
		.wait_s        (wait_s)
	);

	// Event flags wait here while the interval is computed.
	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= alarm_res;
		end
		if (wait_cmd.take) begin
			res_q  <= flags_s1;
			wait_q <= wait_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wait_cmd.take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign plugged_event   = res_q.plugged;
	assign unplugged_event = res_q.unplugged;
	assign unplug_step     = res_q.step;
	assign warn_fired      = res_q.warn;
	assign urgent_fired    = res_q.urgent;
	assign shelter_fired   = res_q.shelter;
	assign shelter_request = res_q.request;
	assign next_wait_s     = wait_q;

	`BTM_ASSERT_IMP(a_no_overwrite, out_valid_q && !out_ready, !wait_cmd.take)
	`BTM_ASSERT_NXT(a_busy_after_accept, accept, !in_ready)
	`BTM_ASSERT_NXT(a_take_fills_output, wait_cmd.take, out_valid_q)

endmodule

[tb/tb_battery_threshold_monitor.sv]
// Self-checking testbench for the battery threshold monitor, with its scoreboard class.

// One result item of the block as the scoreboard stores it.
typedef struct packed {
	bthm_pkg::alarm_res_t            flags;
	logic [bthm_pkg::WAIT_W-1:0]     wait_s;
} battery_report_t;

// Keeps its own copy of the registers and of the alarm state, works out the report
// that each accepted reading must produce and checks the reports that come out.
class battery_alarm_scoreboard;
	logic [bthm_pkg::PCT_W-1:0]  warn_lvl;
	logic [bthm_pkg::PCT_W-1:0]  urgent_lvl;
	logic [bthm_pkg::PCT_W-1:0]  shelter_lvl;
	logic [bthm_pkg::KIND_W-1:0] kind_sel;
	logic [2:0]                  armed;
	bit                          mains_prev;
	bit                          mains_seen;
	bit                          shelter_latched;
	battery_report_t             due_reports[$];
	int                          errors;

	function new();
		warn_lvl        = bthm_pkg::RST_WARN_LEVEL;
		urgent_lvl      = bthm_pkg::RST_URGENT_LEVEL;
		shelter_lvl     = bthm_pkg::RST_SHELTER_LEVEL;
		kind_sel        = bthm_pkg::RST_SHELTER_KIND;
		armed           = 3'b111;
		mains_prev      = 1'b0;
		mains_seen      = 1'b0;
		shelter_latched = 1'b0;
		errors          = 0;
	endfunction

	function void set_register(logic [bthm_pkg::CFG_IDX_W-1:0] idx,
			logic [bthm_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			bthm_pkg::CFG_WARN:    warn_lvl    = data;
			bthm_pkg::CFG_URGENT:  urgent_lvl  = data;
			bthm_pkg::CFG_SHELTER: shelter_lvl = data;
			bthm_pkg::CFG_KIND:    kind_sel    = data[bthm_pkg::KIND_W-1:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return due_reports.size();
	endfunction

	// Seconds until the next reading: a quarter of the time left before the charge
	// reaches the highest threshold below the present percent, clamped.
	function logic [bthm_pkg::WAIT_W-1:0] read_interval(int pct, bit mains, bit ok,
			logic [31:0] now, logic [31:0] full, logic [31:0] drain);
		int          lvl[3];
		int          tgt;
		bit          found;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] q;
		if (mains)
			return bthm_pkg::WAIT_MAINS;
		lvl[0] = warn_lvl;
		lvl[1] = urgent_lvl;
		lvl[2] = shelter_lvl;
		tgt = 0;
		found = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (lvl[i] < pct && (!found || lvl[i] > tgt)) begin
				tgt = lvl[i];
				found = 1'b1;
			end
		end
		if (!ok || full == 0 || drain == 0)
			return bthm_pkg::WAIT_BLIND;
		a = 64'(now) * 64'd100;
		b = 64'(full) * 64'(tgt);
		if (a <= b)
			return bthm_pkg::WAIT_MIN;
		q = ((a - b) * 64'd9) / 64'(drain);
		if (q < 64'(bthm_pkg::WAIT_MIN))
			return bthm_pkg::WAIT_MIN;
		if (q > 64'(bthm_pkg::WAIT_MAX))
			return bthm_pkg::WAIT_MAX;
		return q[bthm_pkg::WAIT_W-1:0];
	endfunction

	// Advances the alarm state by one accepted reading and queues its report.
	function void take_reading(logic [bthm_pkg::PCT_W-1:0] pct, logic mains, logic rd_ok,
			logic ch_ok, logic [31:0] now, logic [31:0] full, logic [31:0] drain);
		battery_report_t r;
		int              lvl[3];
		int              step;
		r = '0;
		if (!rd_ok) begin
			r.wait_s = bthm_pkg::WAIT_BLIND;
			due_reports.push_back(r);
			return;
		end
		if (mains_seen) begin
			if (mains && !mains_prev) begin
				r.flags.plugged = 1'b1;
				armed = 3'b111;
				shelter_latched = 1'b0;
			end else if (!mains && mains_prev) begin
				r.flags.unplugged = 1'b1;
				step = (int'(pct) + 5) / 10 * 10;
				if (step > 100)
					step = 100;
				r.flags.step = step[bthm_pkg::STEP_W-1:0];
			end
		end
		mains_seen = 1'b1;
		mains_prev = mains;
		if (!mains) begin
			lvl[0] = warn_lvl;
			lvl[1] = urgent_lvl;
			lvl[2] = shelter_lvl;
			for (int i = 0; i < 3; i++) begin
				if (!armed[i] && int'(pct) > lvl[i] + int'(bthm_pkg::REARM_MARGIN))
					armed[i] = 1'b1;
				if (armed[i] && int'(pct) <= lvl[i]) begin
					armed[i] = 1'b0;
					case (i)
						0: r.flags.warn = 1'b1;
						1: r.flags.urgent = 1'b1;
						default: begin
							if (!shelter_latched) begin
								shelter_latched = 1'b1;
								r.flags.shelter = 1'b1;
								r.flags.request = kind_sel;
							end
						end
					endcase
				end
			end
		end
		r.wait_s = read_interval(pct, mains, ch_ok, now, full, drain);
		due_reports.push_back(r);
	endfunction

	function void note_error(string what, int want, int got);
		errors++;
		if (errors <= 10)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
	endfunction

	function void compare_field(string what, int want, int got);
		if (want != got)
			note_error(what, want, got);
	endfunction

	function void check_report(battery_report_t got);
		battery_report_t want;
		if (due_reports.size() == 0) begin
			note_error("result with nothing awaited, next_wait_s", 0, got.wait_s);
			return;
		end
		want = due_reports.pop_front();
		compare_field("plugged_event", want.flags.plugged, got.flags.plugged);
		compare_field("unplugged_event", want.flags.unplugged, got.flags.unplugged);
		compare_field("unplug_step", want.flags.step, got.flags.step);
		compare_field("warn_fired", want.flags.warn, got.flags.warn);
		compare_field("urgent_fired", want.flags.urgent, got.flags.urgent);
		compare_field("shelter_fired", want.flags.shelter, got.flags.shelter);
		compare_field("shelter_request", want.flags.request, got.flags.request);
		compare_field("next_wait_s", want.wait_s, got.wait_s);
	endfunction
endclass

module tb_battery_threshold_monitor;

	// The slowest correct run is bounded by the sender gap, the interval arithmetic and the
	// longest receiver stall, so this limit leaves a wide margin.
	localparam int CYCLE_LIMIT = 600000;
	// Items per random phase; nine phases give about 1350 random items.
	localparam int PHASE_ITEMS = 150;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [bthm_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [bthm_pkg::CFG_DATA_W-1:0]    cfg_data;
	logic                               in_valid;
	logic                               in_ready;
	logic [bthm_pkg::PCT_W-1:0]         level_percent;
	logic                               mains_present;
	logic                               reading_ok;
	logic                               charge_ok;
	logic [bthm_pkg::DATA_W-1:0]        charge_left;
	logic [bthm_pkg::DATA_W-1:0]        charge_cap;
	logic [bthm_pkg::DATA_W-1:0]        drain_now;
	logic                               out_valid;
	logic                               out_ready;
	logic                               plugged_event;
	logic                               unplugged_event;
	logic [bthm_pkg::STEP_W-1:0]        unplug_step;
	logic                               warn_fired;
	logic                               urgent_fired;
	logic                               shelter_fired;
	logic [bthm_pkg::KIND_W-1:0]        shelter_request;
	logic [bthm_pkg::WAIT_W-1:0]        next_wait_s;

	battery_alarm_scoreboard sb = new();

	int cycles;
	int burst_left;
	int phase_sent;

	battery_threshold_monitor dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.level_percent   (level_percent),
		.mains_present   (mains_present),
		.reading_ok      (reading_ok),
		.charge_ok       (charge_ok),
		.charge_left     (charge_left),
		.charge_cap      (charge_cap),
		.drain_now       (drain_now),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.plugged_event   (plugged_event),
		.unplugged_event (unplugged_event),
		.unplug_step     (unplug_step),
		.warn_fired      (warn_fired),
		.urgent_fired    (urgent_fired),
		.shelter_fired   (shelter_fired),
		.shelter_request (shelter_request),
		.next_wait_s     (next_wait_s)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The watchdog ends a run that hangs, for instance when the block stops taking items.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Every result item that moves is checked against the oldest awaited report.
	always @(posedge clk) begin : watch_results
		battery_report_t got;
		if (arst_n && out_valid && out_ready) begin
			got.flags.plugged   = plugged_event;
			got.flags.unplugged = unplugged_event;
			got.flags.step      = unplug_step;
			got.flags.warn      = warn_fired;
			got.flags.urgent    = urgent_fired;
			got.flags.shelter   = shelter_fired;
			got.flags.request   = shelter_request;
			got.wait_s          = next_wait_s;
			sb.check_report(got);
		end
	end

	// The receiver switches between stall patterns of random length: always ready,
	// mostly ready, a fixed duty cycle, and long alternating runs of stall or ready.
	initial begin : receiver
		int rx_mode;
		int rx_left;
		int rx_hold;
		int rx_tick;
		out_ready = 1'b0;
		rx_mode = 0;
		rx_left = 0;
		rx_hold = 0;
		rx_tick = 0;
		forever begin
			@(negedge clk);
			rx_tick++;
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ((rx_tick % 5) < 2);
				default: begin
					if (rx_hold == 0) begin
						out_ready <= ~out_ready;
						rx_hold = $urandom_range(1, 30);
					end else begin
						rx_hold--;
					end
				end
			endcase
		end
	end

	// Offers one reading at the present falling edge and holds it until it is taken.
	// After the item the sender may take a random gap; bursts and gaps have random
	// lengths, and now and then a long burst runs with no gap at all.
	task automatic send_reading(input int pct, input logic mains, input logic rd_ok,
			input logic ch_ok, input logic [31:0] now, input logic [31:0] full,
			input logic [31:0] drain);
		in_valid      <= 1'b1;
		level_percent <= pct[bthm_pkg::PCT_W-1:0];
		mains_present <= mains;
		reading_ok    <= rd_ok;
		charge_ok     <= ch_ok;
		charge_left   <= now;
		charge_cap    <= full;
		drain_now     <= drain;
		do
			@(posedge clk);
		while (!in_ready);
		sb.take_reading(pct[bthm_pkg::PCT_W-1:0], mains, rd_ok, ch_ok, now, full, drain);
		phase_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			if ($urandom_range(0, 7) == 0)
				burst_left = $urandom_range(40, 120);
			else
				burst_left = $urandom_range(0, 20);
		end
	endtask

	// Holds off the sender until every awaited report has come, then lets the
	// interval unit finish whatever it may still be doing.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// Writes all four registers on consecutive cycles, plus one write to an unused
	// index that the block must ignore. The shelter kind goes out with junk upper bits.
	task automatic program_levels(input int w, input int u, input int s, input int k);
		logic [bthm_pkg::CFG_IDX_W-1:0]  idx[5];
		logic [bthm_pkg::CFG_DATA_W-1:0] val[5];
		idx[0] = bthm_pkg::CFG_WARN;
		idx[1] = bthm_pkg::CFG_URGENT;
		idx[2] = bthm_pkg::CFG_SHELTER;
		idx[3] = bthm_pkg::CFG_KIND;
		idx[4] = bthm_pkg::CFG_KIND + 3'($urandom_range(1, 4));
		val[0] = w[bthm_pkg::CFG_DATA_W-1:0];
		val[1] = u[bthm_pkg::CFG_DATA_W-1:0];
		val[2] = s[bthm_pkg::CFG_DATA_W-1:0];
		val[3] = {5'($urandom_range(0, 31)), k[bthm_pkg::KIND_W-1:0]};
		val[4] = 7'($urandom_range(0, 127));
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(negedge clk);
			sb.set_register(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Charge figures for a reading. Most are plausible, with the drain chosen so the
	// interval lands anywhere across and a little beyond 20..300 s; the rest are the
	// blind cases, an empty battery and fully random words.
	task automatic make_charge(input int pct, output logic ok, output logic [31:0] now,
			output logic [31:0] full, output logic [31:0] drain);
		int          pick;
		logic [63:0] d;
		pick = $urandom_range(0, 99);
		ok   = 1'b1;
		full = $urandom_range(100000, 20000000);
		now  = full / 100 * pct + $urandom_range(0, full / 100);
		d    = 64'(now) * 64'd900 / 64'($urandom_range(10, 400));
		if (d == 0)
			d = 1;
		if (d > 64'hFFFF_FFFF)
			d = 64'hFFFF_FFFF;
		drain = d[31:0];
		if (pick < 5) begin
			ok = 1'b0;
		end else if (pick < 8) begin
			full = 0;
		end else if (pick < 11) begin
			drain = 0;
		end else if (pick < 14) begin
			now = 0;
		end else if (pick < 25) begin
			now   = $urandom;
			full  = $urandom;
			drain = $urandom;
		end
	endtask

	// A plausible reading; about one in ten is a failed percent read.
	task automatic offer_reading(input int pct, input logic mains);
		logic        ok;
		logic [31:0] now;
		logic [31:0] full;
		logic [31:0] drain;
		make_charge(pct, ok, now, full, drain);
		send_reading(pct, mains, ($urandom_range(0, 9) != 0), ok, now, full, drain);
	endtask

	// Anything the ports allow, including percents above 100.
	task automatic send_noise();
		send_reading($urandom_range(0, 127), 1'($urandom), 1'($urandom), 1'($urandom),
			$urandom, $urandom, $urandom);
	endtask

	// One charge and discharge cycle: a few readings on mains, then the percent falls
	// in small steps, with occasional bounces upward to exercise the re-arm margin,
	// until the battery is empty, the session breaks off early or the phase is full.
	task automatic run_session();
		int pct;
		pct = $urandom_range(40, 100);
		repeat ($urandom_range(1, 3)) begin
			offer_reading(pct, 1'b1);
			pct = pct + $urandom_range(0, 5);
			if (pct > 100)
				pct = 100;
		end
		while (pct >= 0) begin
			offer_reading(pct, 1'b0);
			if ($urandom_range(0, 19) == 0)
				send_noise();
			if ($urandom_range(0, 6) == 0)
				pct = pct + $urandom_range(1, 6);
			else
				pct = pct - $urandom_range(0, 3);
			if ($urandom_range(0, 33) == 0)
				break;
			if (phase_sent >= PHASE_ITEMS)
				break;
		end
	endtask

	initial begin : stimulus
		int tab[6][4];
		cycles        = 0;
		burst_left    = 0;
		phase_sent    = 0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		level_percent = '0;
		mains_present = 1'b0;
		reading_ok    = 1'b0;
		charge_ok     = 1'b0;
		charge_left   = '0;
		charge_cap    = '0;
		drain_now     = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// Directed readings with the reset levels 20, 10, 5 and hibernate.
		// The first valid reading only records the mains state, with no event.
		send_reading(50, 1'b0, 1'b1, 1'b1, 32'd5000000, 32'd10000000, 32'd900000);
		// A failed reading changes nothing and reports only the blind interval.
		send_reading(127, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_reading(127, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
		send_reading(100, 1'b1, 1'b1, 1'b1, 32'd7000000, 32'd7000000, 32'd300000);
		// Unplug steps: 95 rounds up to 100, and 127 is capped at 100.
		send_reading(95, 1'b0, 1'b1, 1'b1, 32'd9500000, 32'd10000000, 32'd1000000);
		send_reading(127, 1'b1, 1'b1, 1'b1, 32'd0, 32'd10000000, 32'd1000000);
		send_reading(127, 1'b0, 1'b1, 1'b1, 32'd1, 32'd1, 32'd1);
		// Down through the thresholds, with each way of losing the charge figures.
		send_reading(20, 1'b0, 1'b1, 1'b0, 32'd2000000, 32'd10000000, 32'd500000);
		send_reading(19, 1'b0, 1'b1, 1'b1, 32'd1900000, 32'd0, 32'd500000);
		send_reading(10, 1'b0, 1'b1, 1'b1, 32'd1000000, 32'd10000000, 32'd0);
		// Shelter fires; an empty battery gives the shortest interval.
		send_reading(5, 1'b0, 1'b1, 1'b1, 32'd0, 32'd10000000, 32'd500000);
		// A tiny quotient clamps up to 20 s, a huge one down to 300 s.
		send_reading(4, 1'b0, 1'b1, 1'b1, 32'd1, 32'd1, 32'hFFFF_FFFF);
		send_reading(9, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd1, 32'd1);
		// Shelter re-armed above 8, reached again, but already done this discharge.
		send_reading(5, 1'b0, 1'b1, 1'b1, 32'd500000, 32'd10000000, 32'd100000);
		send_reading(0, 1'b0, 1'b1, 1'b1, 32'd0, 32'd10000000, 32'd100000);
		// Plug in at zero, then unplug at 3: step 0 and all three alarms at once.
		send_reading(0, 1'b1, 1'b1, 1'b1, 32'd0, 32'd10000000, 32'd100000);
		send_reading(3, 1'b0, 1'b1, 1'b1, 32'd300000, 32'd10000000, 32'd100000);
		// 24 is more than 3 above the warning level, so everything re-arms.
		send_reading(24, 1'b0, 1'b1, 1'b1, 32'd2400000, 32'd10000000, 32'd100000);
		send_reading(23, 1'b0, 1'b1, 1'b1, 32'd2300000, 32'd10000000, 32'd100000);
		send_reading(4, 1'b1, 1'b1, 1'b1, 32'd400000, 32'd10000000, 32'd100000);
		send_reading(4, 1'b0, 1'b1, 1'b1, 32'd400000, 32'd10000000, 32'd100000);

		// With the shelter kind set to none, shelter still fires, requesting nothing.
		settle();
		program_levels(30, 15, 8, 0);
		send_reading(50, 1'b1, 1'b1, 1'b1, 32'd5000000, 32'd10000000, 32'd100000);
		send_reading(8, 1'b0, 1'b1, 1'b1, 32'd800000, 32'd10000000, 32'd100000);

		// Random phases: fixed settings first, some of them extreme, then random ones. Each phase
		// boundary waits for the block to drain completely before the registers change.
		tab[0] = '{0, 0, 0, 0};
		tab[1] = '{100, 100, 100, 3};
		tab[2] = '{127, 127, 127, 2};
		tab[3] = '{50, 30, 10, 3};
		tab[4] = '{10, 20, 30, 0};
		tab[5] = '{20, 10, 5, 1};
		for (int ph = 0; ph < 9; ph++) begin
			settle();
			if (ph < 6)
				program_levels(tab[ph][0], tab[ph][1], tab[ph][2], tab[ph][3]);
			else
				program_levels($urandom_range(0, 100), $urandom_range(0, 100),
					$urandom_range(0, 100), $urandom_range(0, 3));
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 6) == 0)
					send_noise();
				else
					run_session();
			end
		end

		// Drain the pipeline, then give a stray extra result a chance to show up.
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[battery_threshold_monitor.f]
+incdir+src
src/bthm_pkg.sv
src/bthm_alarm.sv
src/bthm_wait.sv
src/battery_threshold_monitor.sv
tb/tb_battery_threshold_monitor.sv
